// ===== rtl/gmcb_pkg.sv =====
package gmcb_pkg;

    // fixed point and field widths
    localparam int FRACTION_BITS = 12;
    localparam int Q_W           = 13;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 52;
    localparam int COUNT_W       = 3;
    localparam int BYTE_W        = 8;

    localparam logic [Q_W-1:0] ONE_Q = 13'd4096;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STOP_COUNT   = 3'd0,
        REG_STOP_ZERO    = 3'd1,
        REG_STOP_ONE     = 3'd2,
        REG_STOP_TWO     = 3'd3,
        REG_STOP_THREE   = 3'd4,
        REG_STOP_FOUR    = 3'd5,
        REG_BLEND_ENABLE = 3'd6,
        REG_MASK_ENABLE  = 3'd7
    } cfg_reg_t;

    typedef logic [Q_W-1:0] q_t;

    typedef struct packed {
        logic signed [19:0] gradient_value;
        logic signed [19:0] mask_value;
        logic [7:0]         base_red;
        logic [7:0]         base_green;
        logic [7:0]         base_blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } result_t;

    // one colour stop, position in the low field
    typedef struct packed {
        q_t blue;
        q_t green;
        q_t red;
        q_t pos;
    } stop_t;

    // classified beat handed from front to back
    typedef struct packed {
        q_t                    diff;
        q_t                    span;
        q_t [2:0]              c_lo;
        q_t [2:0]              c_hi;
        q_t                    weight;
        logic [2:0][BYTE_W-1:0] base;
    } work_t;

    // clamp a signed Q sample to 0..one
    function automatic q_t clamp_unit(input logic signed [19:0] v);
        q_t r;
        if (v < 20'sd0)
            r = '0;
        else if (v > 20'sd4096)
            r = ONE_Q;
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/gmcb_front.sv =====
module gmcb_front #(
    parameter int MAX_STOPS = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [gmcb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gmcb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                pixel_valid,
    input  gmcb_pkg::pixel_t                    pixel,
    output logic                                work_valid,
    output gmcb_pkg::work_t                     work
);

    logic [gmcb_pkg::COUNT_W-1:0] stop_count_reg;
    gmcb_pkg::stop_t              stops_reg [MAX_STOPS];
    logic                         blend_reg;
    logic                         mask_reg;

    logic                         work_valid_reg;
    gmcb_pkg::work_t              work_reg;
    gmcb_pkg::work_t              work_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= '0;
            blend_reg      <= 1'b0;
            mask_reg       <= 1'b0;
            for (int k = 0; k < MAX_STOPS; k++)
                stops_reg[k] <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gmcb_pkg::REG_STOP_COUNT:   stop_count_reg <= cfg_data[gmcb_pkg::COUNT_W-1:0];
                gmcb_pkg::REG_BLEND_ENABLE: blend_reg <= cfg_data[0];
                gmcb_pkg::REG_MASK_ENABLE:  mask_reg  <= cfg_data[0];
                default:
                begin
                    for (int k = 0; k < MAX_STOPS; k++)
                        if (cfg_index == gmcb_pkg::CFG_IDX_W'(int'(gmcb_pkg::REG_STOP_ZERO) + k))
                            stops_reg[k] <= gmcb_pkg::stop_t'(cfg_data);
                end
            endcase
        end
    end

    // segment search and colour pick
    always_comb
    begin
        logic [gmcb_pkg::COUNT_W-1:0] n;
        logic [gmcb_pkg::COUNT_W-1:0] last;
        logic [gmcb_pkg::COUNT_W-1:0] lo;
        logic [gmcb_pkg::COUNT_W-1:0] hi;
        gmcb_pkg::q_t                 t;
        gmcb_pkg::q_t                 last_pos;
        logic                         black;
        logic                         found;

        n = (stop_count_reg > gmcb_pkg::COUNT_W'(MAX_STOPS))
            ? gmcb_pkg::COUNT_W'(MAX_STOPS) : stop_count_reg;
        last     = n - 3'd1;
        black    = (n == '0);
        t        = gmcb_pkg::clamp_unit(pixel.gradient_value);
        last_pos = '0;
        for (int i = 0; i < MAX_STOPS; i++)
            if (gmcb_pkg::COUNT_W'(i) == last)
                last_pos = stops_reg[i].pos;

        work_next      = '0;
        work_next.span = gmcb_pkg::Q_W'(1);
        lo    = '0;
        hi    = '0;
        found = 1'b0;
        if (!black)
        begin
            if (t <= stops_reg[0].pos)
            begin
                lo = '0;
                hi = '0;
            end
            else if (t >= last_pos)
            begin
                lo = last;
                hi = last;
            end
            else
            begin
                lo = last;
                hi = last;
                for (int i = 0; i < MAX_STOPS - 1; i++)
                begin
                    if (!found && (gmcb_pkg::COUNT_W'(i + 1) < n) &&
                        (t <= stops_reg[i+1].pos))
                    begin
                        found = 1'b1;
                        lo    = gmcb_pkg::COUNT_W'(i);
                        hi    = gmcb_pkg::COUNT_W'(i + 1);
                        if (stops_reg[i+1].pos > stops_reg[i].pos)
                        begin
                            work_next.diff = t - stops_reg[i].pos;
                            work_next.span = stops_reg[i+1].pos - stops_reg[i].pos;
                        end
                    end
                end
            end
            for (int i = 0; i < MAX_STOPS; i++)
            begin
                if (gmcb_pkg::COUNT_W'(i) == lo)
                    work_next.c_lo = {stops_reg[i].blue, stops_reg[i].green, stops_reg[i].red};
                if (gmcb_pkg::COUNT_W'(i) == hi)
                    work_next.c_hi = {stops_reg[i].blue, stops_reg[i].green, stops_reg[i].red};
            end
        end

        // blend weight from the mask value, one when blending or masking is off
        if (blend_reg && mask_reg)
            work_next.weight = gmcb_pkg::clamp_unit(pixel.mask_value);
        else
            work_next.weight = gmcb_pkg::ONE_Q;
        work_next.base = {pixel.base_blue, pixel.base_green, pixel.base_red};
    end

    // front output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            work_valid_reg <= 1'b0;
        else
            work_valid_reg <= pixel_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pixel_valid)
            work_reg <= work_next;
    end

    assign work_valid = work_valid_reg;
    assign work       = work_reg;

endmodule

// ===== rtl/gmcb_queue.sv =====
module gmcb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gmcb_pkg::work_t push_data,
    input  logic            pop,
    output logic            head_valid,
    output gmcb_pkg::work_t head,
    output logic            full
);

    gmcb_pkg::work_t entries [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            do_pop;

    assign do_pop = pop && (count_reg != 2'd0);

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, do_pop};
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_data;
    end

    assign head       = entries[rd_ptr_reg];
    assign head_valid = (count_reg != 2'd0);
    assign full       = (count_reg == 2'd2);

endmodule

// ===== rtl/gmcb_back.sv =====
module gmcb_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  gmcb_pkg::work_t   in_work,
    output logic              result_valid,
    output gmcb_pkg::result_t result
);

    localparam int DIV_STAGES = gmcb_pkg::Q_W;

    typedef struct packed {
        gmcb_pkg::work_t w;
        gmcb_pkg::q_t    rem;
        gmcb_pkg::q_t    quo;
    } div_t;

    // one quotient bit of the restoring divider
    function automatic div_t div_step(input div_t s, input int k);
        div_t                  r;
        logic [gmcb_pkg::Q_W:0] shifted;
        logic [gmcb_pkg::Q_W:0] diffd;
        r       = s;
        shifted = {s.rem, (k == 0) ? s.w.diff[0] : 1'b0};
        diffd   = shifted - {1'b0, s.w.span};
        if (shifted >= {1'b0, s.w.span})
        begin
            r.rem = diffd[gmcb_pkg::Q_W-1:0];
            r.quo[gmcb_pkg::Q_W-1-k] = 1'b1;
        end
        else
            r.rem = shifted[gmcb_pkg::Q_W-1:0];
        return r;
    endfunction

    div_t                    div_reg   [DIV_STAGES+1];
    logic                    div_v_reg [DIV_STAGES+1];

    logic                    i1_v_reg;
    gmcb_pkg::work_t         i1_reg;
    logic signed [27:0]      prod_reg [3];

    logic                    i2_v_reg;
    gmcb_pkg::q_t            i2_weight_reg;
    logic [2:0][7:0]         i2_base_reg;
    gmcb_pkg::q_t            col_reg [3];

    logic                    b1_v_reg;
    logic [20:0]             x_reg [3];
    logic [25:0]             y_reg [3];

    logic                    res_v_reg;
    gmcb_pkg::result_t       res_reg;
    gmcb_pkg::result_t       res_next;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
                div_v_reg[k] <= 1'b0;
            i1_v_reg  <= 1'b0;
            i2_v_reg  <= 1'b0;
            b1_v_reg  <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            div_v_reg[0] <= in_valid;
            for (int k = 0; k < DIV_STAGES; k++)
                div_v_reg[k+1] <= div_v_reg[k];
            i1_v_reg  <= div_v_reg[DIV_STAGES];
            i2_v_reg  <= i1_v_reg;
            b1_v_reg  <= i2_v_reg;
            res_v_reg <= b1_v_reg;
        end
    end

    // segment weight divider, one bit a stage
    always_ff @(posedge clk)
    begin
        div_reg[0].w   <= in_work;
        div_reg[0].rem <= {1'b0, in_work.diff[gmcb_pkg::Q_W-1:1]};
        div_reg[0].quo <= '0;
        for (int k = 0; k < DIV_STAGES; k++)
            div_reg[k+1] <= div_step(div_reg[k], k);
    end

    // interpolation product
    always_ff @(posedge clk)
    begin
        i1_reg <= div_reg[DIV_STAGES].w;
        for (int c = 0; c < 3; c++)
            prod_reg[c] <= $signed({1'b0, div_reg[DIV_STAGES].quo})
                * ($signed({1'b0, div_reg[DIV_STAGES].w.c_hi[c]})
                 - $signed({1'b0, div_reg[DIV_STAGES].w.c_lo[c]}));
    end

    // truncate toward zero and add lower stop
    always_ff @(posedge clk)
    begin
        logic signed [27:0] adj;
        logic signed [15:0] sum;
        i2_weight_reg <= i1_reg.weight;
        i2_base_reg   <= i1_reg.base;
        for (int c = 0; c < 3; c++)
        begin
            adj = (prod_reg[c] < 0) ? (prod_reg[c] + 28'sd4095) : prod_reg[c];
            sum = $signed({3'b000, i1_reg.c_lo[c]}) + 16'(adj >>> gmcb_pkg::FRACTION_BITS);
            col_reg[c] <= sum[gmcb_pkg::Q_W-1:0];
        end
    end

    // blend products
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            x_reg[c] <= (gmcb_pkg::ONE_Q - i2_weight_reg) * i2_base_reg[c];
            y_reg[c] <= i2_weight_reg * col_reg[c];
        end
    end

    // sum, scale and saturate
    always_comb
    begin
        logic [34:0] num;
        logic [10:0] byte_v;
        logic [7:0]  chan [3];
        for (int c = 0; c < 3; c++)
        begin
            num = {2'b00, x_reg[c], 12'b0} + {1'b0, y_reg[c], 8'b0} - {9'b0, y_reg[c]};
            byte_v  = num[34:24];
            chan[c] = (byte_v > 11'd255) ? 8'd255 : byte_v[7:0];
        end
        res_next.out_red   = chan[0];
        res_next.out_green = chan[1];
        res_next.out_blue  = chan[2];
        res_next.out_alpha = 8'd255;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = res_v_reg;
    assign result       = res_reg;

endmodule

// ===== rtl/gradient_map_colorize_blend.sv =====
// path: front, queue, divider, product, rounding, blend and result registers
// throughput: one pixel per cycle, the 13-stage weight divider is fully pipelined
// busy stays low in normal running; the queue between front and back never fills
// results are strobed for one cycle and cannot be held off
// reset is asynchronous, active low; it clears valid flags, pointers and config, not data
module gradient_map_colorize_blend #(
    parameter int MAX_STOPS = 5
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  gmcb_pkg::pixel_t                pixel,
    output logic                            result_valid,
    output gmcb_pkg::result_t               result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gmcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gmcb_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic            accept;
    logic            work_valid;
    gmcb_pkg::work_t work;
    logic            head_valid;
    gmcb_pkg::work_t head;
    logic            q_full;

    assign accept    = start && !busy;
    assign busy      = q_full;
    assign cfg_ready = 1'b1;

    // classify pixel against stops
    gmcb_front #(
        .MAX_STOPS (MAX_STOPS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (accept),
        .pixel       (pixel),
        .work_valid  (work_valid),
        .work        (work)
    );

    // decoupling queue
    gmcb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (work_valid),
        .push_data  (work),
        .pop        (1'b1),
        .head_valid (head_valid),
        .head       (head),
        .full       (q_full)
    );

    // interpolate and blend
    gmcb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (head_valid),
        .in_work      (head),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== rtl/gmcb_checker.sv =====
module gmcb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              result_valid,
    input gmcb_pkg::result_t result,
    input logic              cfg_valid,
    input logic              cfg_ready
);

    // every accepted beat gives a result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##20 result_valid)
        else $error("missing result for accepted beat");

    // alpha is always opaque
    a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.out_alpha == 8'd255)
        else $error("alpha not opaque");

    // queue never backs up
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // configuration writes are never refused
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind gradient_map_colorize_blend gmcb_checker u_gmcb_checker (.*);
